// ===== rtl/core/fpq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fpq_pkg
// shared sizes, operation and status codes, controller states and the
// command bundle of the four-level priority queue
// ----------------------------------------------------------------------------
package fpq_pkg;

	// storage sizes
	localparam int CAPACITY = 16;
	localparam int TAG_BITS = 16;

	// fixed field widths
	localparam int MODE_W  = 2;
	localparam int TAG_W   = 16;
	localparam int LVL_W   = 3;
	localparam int STAT_W  = 2;
	localparam int ENTRY_W = 5;

	// stored tag width: only the low TAG_BITS bits of a tag are kept
	localparam int SLOT_TAG_W = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
	// held count must reach CAPACITY itself
	localparam int CNT_W      = $clog2(CAPACITY + 1);

	// operations
	localparam logic [MODE_W-1:0] MODE_PUSH   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_POP    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;

	// result status
	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

	// urgency range
	localparam logic [LVL_W-1:0] LEVEL_BOTTOM = 3'd1;
	localparam logic [LVL_W-1:0] LEVEL_TOP    = 3'd4;

	typedef enum logic [1:0] {
		CTL_IDLE,
		CTL_EXEC,
		CTL_RESP
	} ctl_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;   // capture the incoming item
		logic exec;   // carry out the captured operation
	} dp_cmd_t;

endpackage : fpq_pkg
`default_nettype wire

// ===== rtl/core/fpq_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fpq_ctrl
// sequencer: accepts an item, runs it through the datapath, then holds the
// result until the output side takes it
// ----------------------------------------------------------------------------
module fpq_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output fpq_pkg::dp_cmd_t     cmd
);
	import fpq_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CTL_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		cmd       = '0;
		unique case (state_q)
			CTL_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = CTL_EXEC;
				end
			end
			CTL_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = CTL_RESP;
			end
			CTL_RESP: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					state_d = CTL_IDLE;
				end
			end
			default: begin
				state_d = CTL_IDLE;
			end
		endcase
	end

	// one item in flight: no input taken while a result waits
	a_no_accept_while_resp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input accepted while a result is pending");

	// every load is followed by exactly one execute
	a_load_then_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (cmd.exec && !cmd.load))
		else $error("load not followed by execute");

	// result appears the cycle after execute
	a_exec_then_resp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> out_valid)
		else $error("execute not followed by result");

endmodule : fpq_ctrl
`default_nettype wire

// ===== rtl/core/fpq_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fpq_datapath
// sorted slot array with parallel insert, pop and search, plus the
// result registers
// ----------------------------------------------------------------------------
module fpq_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire fpq_pkg::dp_cmd_t              cmd,
	input  wire logic [fpq_pkg::MODE_W-1:0]    mode,
	input  wire logic [fpq_pkg::TAG_W-1:0]     item_tag,
	input  wire logic [fpq_pkg::LVL_W-1:0]     priority_level,
	output logic      [fpq_pkg::TAG_W-1:0]     result_tag,
	output logic      [fpq_pkg::LVL_W-1:0]     result_level,
	output logic      [fpq_pkg::STAT_W-1:0]    status,
	output logic      [fpq_pkg::ENTRY_W-1:0]   entry_count
);
	import fpq_pkg::*;

	// captured operation
	logic [MODE_W-1:0]     op_mode_q;
	logic [SLOT_TAG_W-1:0] op_tag_q;
	logic [LVL_W-1:0]      op_lvl_q;

	// slot array, slot 0 is the head
	logic [SLOT_TAG_W-1:0] slot_tag_q [CAPACITY];
	logic [LVL_W-1:0]      slot_lvl_q [CAPACITY];
	logic [SLOT_TAG_W-1:0] slot_tag_d [CAPACITY];
	logic [LVL_W-1:0]      slot_lvl_d [CAPACITY];
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      count_d;

	// result registers
	logic [TAG_W-1:0]  res_tag_q;
	logic [LVL_W-1:0]  res_lvl_q;
	logic [STAT_W-1:0] res_stat_q;
	logic [TAG_W-1:0]  res_tag_d;
	logic [LVL_W-1:0]  res_lvl_d;
	logic [STAT_W-1:0] res_stat_d;

	logic [LVL_W-1:0]    lvl_clamp;
	logic [CAPACITY-1:0] occupied;
	logic [CAPACITY-1:0] keep;
	logic [CAPACITY-1:0] match;
	logic [LVL_W-1:0]    found_lvl;
	logic                full;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_mode_q <= mode;
			op_tag_q  <= item_tag[SLOT_TAG_W-1:0];
			op_lvl_q  <= priority_level;
		end
		if (cmd.exec) begin
			slot_tag_q <= slot_tag_d;
			slot_lvl_q <= slot_lvl_d;
			res_tag_q  <= res_tag_d;
			res_lvl_q  <= res_lvl_d;
			res_stat_q <= res_stat_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			count_q <= count_d;
		end
	end

	// per-slot compares
	always_comb begin
		if (op_lvl_q < LEVEL_BOTTOM) begin
			lvl_clamp = LEVEL_BOTTOM;
		end else if (op_lvl_q > LEVEL_TOP) begin
			lvl_clamp = LEVEL_TOP;
		end else begin
			lvl_clamp = op_lvl_q;
		end
		for (int i = 0; i < CAPACITY; i++) begin
			occupied[i] = count_q > CNT_W'(i);
			keep[i]     = occupied[i] && (slot_lvl_q[i] >= lvl_clamp);
			match[i]    = occupied[i] && (slot_tag_q[i] == op_tag_q);
		end
		full      = count_q == CNT_W'(CAPACITY);
		// first match from the head wins
		found_lvl = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (match[i]) begin
				found_lvl = slot_lvl_q[i];
			end
		end
	end

	// operation decode
	always_comb begin
		slot_tag_d = slot_tag_q;
		slot_lvl_d = slot_lvl_q;
		count_d    = count_q;
		res_tag_d  = '0;
		res_lvl_d  = '0;
		res_stat_d = ST_OK;
		unique case (op_mode_q)
			MODE_PUSH: begin
				if (full) begin
					res_stat_d = ST_FULL;
				end else begin
					// insert point is the first slot not kept
					if (!keep[0]) begin
						slot_tag_d[0] = op_tag_q;
						slot_lvl_d[0] = lvl_clamp;
					end
					for (int i = 1; i < CAPACITY; i++) begin
						if (!keep[i]) begin
							if (keep[i-1]) begin
								slot_tag_d[i] = op_tag_q;
								slot_lvl_d[i] = lvl_clamp;
							end else begin
								slot_tag_d[i] = slot_tag_q[i-1];
								slot_lvl_d[i] = slot_lvl_q[i-1];
							end
						end
					end
					count_d = count_q + 1'b1;
				end
			end
			MODE_POP: begin
				if (count_q == '0) begin
					res_stat_d = ST_EMPTY;
				end else begin
					res_tag_d = TAG_W'(slot_tag_q[0]);
					res_lvl_d = slot_lvl_q[0];
					for (int i = 0; i < CAPACITY - 1; i++) begin
						slot_tag_d[i] = slot_tag_q[i+1];
						slot_lvl_d[i] = slot_lvl_q[i+1];
					end
					count_d = count_q - 1'b1;
				end
			end
			MODE_SEARCH: begin
				if (|match) begin
					res_lvl_d = found_lvl;
				end else begin
					res_stat_d = ST_NOT_FOUND;
				end
			end
			default: begin
				res_stat_d = ST_OK;
			end
		endcase
	end

	assign result_tag   = res_tag_q;
	assign result_level = res_lvl_q;
	assign status       = res_stat_q;
	assign entry_count  = ENTRY_W'(count_q);

	// fill never passes capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("held count beyond capacity");

	// a successful pop shrinks the queue by one
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && op_mode_q == MODE_POP && count_q != '0)
		|=> count_q == $past(count_q) - 1'b1)
		else $error("pop did not remove one entry");

	// head stays the most urgent entry
	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CNT_W'(2)) |-> (slot_lvl_q[0] >= slot_lvl_q[1]))
		else $error("slot order broken at head");

endmodule : fpq_datapath
`default_nettype wire

// ===== rtl/core/four_level_priority_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// four_level_priority_queue
// bounded priority queue, four urgency levels, sorted highest level first
// with equal levels served in arrival order; push, pop and search by tag
// ----------------------------------------------------------------------------
//
//  channel  handshake             payload
//  -------  --------------------  ----------------------------------------
//  input    in_valid / in_stall   mode, item_tag, priority_level
//  output   out_valid / out_stall result_tag, result_level, status,
//                                 entry_count
//
//  an item is captured at its accepting edge; the next cycle runs it
//  through the slot array into the result register, so the result shows
//  once that register has loaded, and is held there until it is taken
//  the slot array does insert, pop and search on all slots in parallel in
//  its execute step; the sequencer takes the next item only once the
//  previous result has been taken, so no new item is accepted while
//  out_stall is held
//  reset empties the queue at once; slot contents are left as they are
//
module four_level_priority_queue (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// input channel
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [fpq_pkg::MODE_W-1:0]    mode,
	input  wire logic [fpq_pkg::TAG_W-1:0]     item_tag,
	input  wire logic [fpq_pkg::LVL_W-1:0]     priority_level,
	// output channel
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic      [fpq_pkg::TAG_W-1:0]     result_tag,
	output logic      [fpq_pkg::LVL_W-1:0]     result_level,
	output logic      [fpq_pkg::STAT_W-1:0]    status,
	output logic      [fpq_pkg::ENTRY_W-1:0]   entry_count
);
	import fpq_pkg::*;

	// command bundle from sequencer to slot array
	dp_cmd_t cmd;

	// sequencer: idle, execute, hold result
	fpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// slot array and result registers; results stay stable while stalled
	// since they only load on execute
	fpq_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.mode           (mode),
		.item_tag       (item_tag),
		.priority_level (priority_level),
		.result_tag     (result_tag),
		.result_level   (result_level),
		.status         (status),
		.entry_count    (entry_count)
	);

endmodule : four_level_priority_queue
`default_nettype wire
